// File: hw/rtl/spa_pkg.sv
package spa_pkg;

  localparam int MAX_TERMS   = 16;
  localparam int MAX_RESULTS = 32;

  localparam int COEFF_W = 16;
  localparam int EXP_W   = 8;
  localparam int SUM_W   = COEFF_W + 1;
  localparam int WORD_W  = COEFF_W + EXP_W;

  localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_START       = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic                    take_a;
    logic                    take_b;
    logic                    emit;
    logic signed [SUM_W-1:0] coeff;
    logic [EXP_W-1:0]        exp;
  } step_t;

endpackage

// File: hw/rtl/spa_ram.sv
module spa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/spa_step.sv
module spa_step import spa_pkg::*; (
  input  logic                      a_valid_i,
  input  logic                      b_valid_i,
  input  logic signed [COEFF_W-1:0] a_coeff_i,
  input  logic [EXP_W-1:0]          a_exp_i,
  input  logic signed [COEFF_W-1:0] b_coeff_i,
  input  logic [EXP_W-1:0]          b_exp_i,
  output step_t                     step_o
);

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] sum;

  assign a_ext = {a_coeff_i[COEFF_W-1], a_coeff_i};
  assign b_ext = {b_coeff_i[COEFF_W-1], b_coeff_i};
  assign sum   = a_ext + b_ext;

  always_comb begin
    step_o = '0;
    if (!b_valid_i || (a_valid_i && (a_exp_i < b_exp_i))) begin
      step_o.take_a = 1'b1;
      step_o.emit   = 1'b1;
      step_o.coeff  = a_ext;
      step_o.exp    = a_exp_i;
    end else if (!a_valid_i || (b_exp_i < a_exp_i)) begin
      step_o.take_b = 1'b1;
      step_o.emit   = 1'b1;
      step_o.coeff  = b_ext;
      step_o.exp    = b_exp_i;
    end else begin
      // equal exponents: add, drop on zero
      step_o.take_a = 1'b1;
      step_o.take_b = 1'b1;
      step_o.emit   = (sum != '0);
      step_o.coeff  = sum;
      step_o.exp    = a_exp_i;
    end
  end

endmodule

// File: hw/rtl/sparse_polynomial_adder.sv
// Channel  Direction  Handshake                Payload
// in       request    in_valid_i / in_stall_o  command_i, term_coeff_i, term_exp_i
// out      result     out_valid_o / out_stall_i
//                                              sum_coeff_o, sum_exp_o, is_last_o,
//                                              is_zero_o, dropped_o
//
// A load request writes one term into its store, or sets the overflow flag when the store is
// full. A start request walks both stores through one compare/add unit; each merge step is a
// registered store read (ST_FETCH), then a compare (ST_STEP), and ST_FLUSH emits the final result.
// One result is held back so the final one can carry is_last.
// Reset empties both stores and clears the overflow flag.
// in_stall_o is high for the whole merge; out_stall_i pauses the merge.
module sparse_polynomial_adder import spa_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic signed [COEFF_W-1:0] term_coeff_i,
  input  logic [EXP_W-1:0]          term_exp_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SUM_W-1:0]   sum_coeff_o,
  output logic [EXP_W-1:0]          sum_exp_o,
  output logic                      is_last_o,
  output logic                      is_zero_o,
  output logic                      dropped_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] first_count_q, first_count_d;
  logic [CNT_W-1:0] second_count_q, second_count_d;
  logic             overflow_q, overflow_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [RES_W-1:0] n_q, n_d;

  logic                    pend_valid_q, pend_valid_d;
  logic signed [SUM_W-1:0] pend_coeff_q, pend_coeff_d;
  logic [EXP_W-1:0]        pend_exp_q, pend_exp_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_coeff_q, out_coeff_d;
  logic [EXP_W-1:0]        out_exp_q, out_exp_d;
  logic                    out_last_q, out_last_d;
  logic                    out_zero_q, out_zero_d;
  logic                    out_drop_q, out_drop_d;

  logic              in_accept;
  logic              out_free;
  logic              we_first;
  logic              we_second;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] first_rdata;
  logic [WORD_W-1:0] second_rdata;
  logic              a_valid;
  logic              b_valid;
  step_t             step;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign wdata      = {term_coeff_i, term_exp_i};

  spa_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TERMS)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we_first),
    .waddr_i (first_count_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (i_q[ADDR_W-1:0]),
    .rdata_o (first_rdata)
  );

  spa_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TERMS)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we_second),
    .waddr_i (second_count_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (j_q[ADDR_W-1:0]),
    .rdata_o (second_rdata)
  );

  assign a_valid = (i_q < first_count_q);
  assign b_valid = (j_q < second_count_q);

  spa_step u_step (
    .a_valid_i (a_valid),
    .b_valid_i (b_valid),
    .a_coeff_i (first_rdata[WORD_W-1:EXP_W]),
    .a_exp_i   (first_rdata[EXP_W-1:0]),
    .b_coeff_i (second_rdata[WORD_W-1:EXP_W]),
    .b_exp_i   (second_rdata[EXP_W-1:0]),
    .step_o    (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      first_count_q  <= '0;
      second_count_q <= '0;
      overflow_q     <= 1'b0;
      i_q            <= '0;
      j_q            <= '0;
      n_q            <= '0;
      pend_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      overflow_q     <= overflow_d;
      i_q            <= i_d;
      j_q            <= j_d;
      n_q            <= n_d;
      pend_valid_q   <= pend_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_coeff_q <= pend_coeff_d;
    pend_exp_q   <= pend_exp_d;
    out_coeff_q  <= out_coeff_d;
    out_exp_q    <= out_exp_d;
    out_last_q   <= out_last_d;
    out_zero_q   <= out_zero_d;
    out_drop_q   <= out_drop_d;
  end

  always_comb begin
    state_d        = state_q;
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    overflow_d     = overflow_q;
    i_d            = i_q;
    j_d            = j_q;
    n_d            = n_q;
    pend_valid_d   = pend_valid_q;
    pend_coeff_d   = pend_coeff_q;
    pend_exp_d     = pend_exp_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_coeff_d    = out_coeff_q;
    out_exp_d      = out_exp_q;
    out_last_d     = out_last_q;
    out_zero_d     = out_zero_q;
    out_drop_d     = out_drop_q;
    we_first       = 1'b0;
    we_second      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (cmd_e'(command_i))
            CMD_LOAD_FIRST: begin
              if (first_count_q < CNT_W'(MAX_TERMS)) begin
                we_first      = 1'b1;
                first_count_d = first_count_q + 1'b1;
              end else begin
                overflow_d = 1'b1;
              end
            end
            CMD_LOAD_SECOND: begin
              if (second_count_q < CNT_W'(MAX_TERMS)) begin
                we_second      = 1'b1;
                second_count_d = second_count_q + 1'b1;
              end else begin
                overflow_d = 1'b1;
              end
            end
            CMD_START: begin
              i_d = '0;
              j_d = '0;
              n_d = '0;
              if (first_count_q == '0 && second_count_q == '0) begin
                state_d = ST_FLUSH;
              end else begin
                state_d = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (!pend_valid_q || out_free) begin
          i_d = i_q + CNT_W'(step.take_a);
          j_d = j_q + CNT_W'(step.take_b);
          if (step.emit) begin
            n_d          = n_q + 1'b1;
            pend_valid_d = 1'b1;
            pend_coeff_d = step.coeff;
            pend_exp_d   = step.exp;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_coeff_d = pend_coeff_q;
              out_exp_d   = pend_exp_q;
              out_last_d  = 1'b0;
              out_zero_d  = 1'b0;
              out_drop_d  = overflow_q;
            end
          end
          if ((i_d >= first_count_q && j_d >= second_count_q) ||
              n_d == RES_W'(MAX_RESULTS)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_last_d     = 1'b1;
          out_drop_d     = overflow_q;
          out_zero_d     = !pend_valid_q;
          out_coeff_d    = pend_valid_q ? pend_coeff_q : '0;
          out_exp_d      = pend_valid_q ? pend_exp_q : '0;
          pend_valid_d   = 1'b0;
          first_count_d  = '0;
          second_count_d = '0;
          overflow_d     = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign sum_coeff_o = out_coeff_q;
  assign sum_exp_o   = out_exp_q;
  assign is_last_o   = out_last_q;
  assign is_zero_o   = out_zero_q;
  assign dropped_o   = out_drop_q;

`ifndef SYNTH
  a_zero_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_zero_o |-> is_last_o)
    else $error("empty-sum result not marked last");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("held result left over after merge");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    i_q <= first_count_q || state_q == ST_IDLE)
    else $error("first read pointer past fill count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_count_q <= CNT_W'(MAX_TERMS) && second_count_q <= CNT_W'(MAX_TERMS))
    else $error("store fill count beyond capacity");

  a_start_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && command_i == CMD_START |=> in_stall_o)
    else $error("input not stalled after start request");
`endif

endmodule

// File: test/tb_sparse_polynomial_adder.sv
module tb_sparse_polynomial_adder;
  import spa_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    logic signed [SUM_W-1:0] coeff;
    logic [EXP_W-1:0]        sexp;
    logic                    last;
    logic                    zero;
    logic                    drop;
  } sum_term_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COEFF_W-1:0] coeff;
    logic [EXP_W-1:0]          texp;
    int                        reps;
    bit                        typed;
    sum_term_t                 want;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                command_i = CMD_LOAD_FIRST;
  logic signed [COEFF_W-1:0] term_coeff_i = '0;
  logic [EXP_W-1:0]          term_exp_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SUM_W-1:0]   sum_coeff_o;
  logic [EXP_W-1:0]          sum_exp_o;
  logic                      is_last_o;
  logic                      is_zero_o;
  logic                      dropped_o;

  sparse_polynomial_adder dut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // predictor state
  logic signed [COEFF_W-1:0] poly_a_coeff [MAX_TERMS];
  logic [EXP_W-1:0]          poly_a_exp   [MAX_TERMS];
  logic signed [COEFF_W-1:0] poly_b_coeff [MAX_TERMS];
  logic [EXP_W-1:0]          poly_b_exp   [MAX_TERMS];
  int                        poly_a_cnt = 0;
  int                        poly_b_cnt = 0;
  bit                        terms_refused = 1'b0;

  sum_term_t sum_terms_due [$];
  sum_term_t due;
  int        err_count = 0;
  int        items_sent = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_pending = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;
  dir_row_t  dir_rows [$];

  function automatic sum_term_t mk_res(int c, int e, bit last, bit zero, bit drop);
    sum_term_t r;
    r.coeff = c[SUM_W-1:0];
    r.sexp  = e[EXP_W-1:0];
    r.last  = last;
    r.zero  = zero;
    r.drop  = drop;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] c, int coeff, int e, int reps, bit typed,
                                      sum_term_t want);
    dir_row_t r;
    r.cmd   = c;
    r.coeff = coeff[COEFF_W-1:0];
    r.texp  = e[EXP_W-1:0];
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic logic signed [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  task automatic merge_sum_terms(output sum_term_t res [$]);
    int i;
    int j;
    logic signed [SUM_W-1:0] ca;
    logic signed [SUM_W-1:0] cb;
    logic signed [SUM_W-1:0] s;
    i = 0;
    j = 0;
    res = {};
    while ((i < poly_a_cnt || j < poly_b_cnt) && res.size() < MAX_RESULTS) begin
      if (j >= poly_b_cnt || (i < poly_a_cnt && poly_a_exp[i] < poly_b_exp[j])) begin
        ca = poly_a_coeff[i];
        res.push_back(mk_res(int'(ca), poly_a_exp[i], 1'b0, 1'b0, terms_refused));
        i++;
      end else if (i >= poly_a_cnt || poly_b_exp[j] < poly_a_exp[i]) begin
        cb = poly_b_coeff[j];
        res.push_back(mk_res(int'(cb), poly_b_exp[j], 1'b0, 1'b0, terms_refused));
        j++;
      end else begin
        ca = poly_a_coeff[i];
        cb = poly_b_coeff[j];
        s = ca + cb;
        if (s != 0) res.push_back(mk_res(int'(s), poly_a_exp[i], 1'b0, 1'b0, terms_refused));
        i++;
        j++;
      end
    end
    if (res.size() == 0) res.push_back(mk_res(0, 0, 1'b0, 1'b1, terms_refused));
    res[res.size()-1].last = 1'b1;
    poly_a_cnt = 0;
    poly_b_cnt = 0;
    terms_refused = 1'b0;
  endtask

  task automatic send_req(logic [1:0] c, logic signed [COEFF_W-1:0] co, logic [EXP_W-1:0] e,
                          bit typed, sum_term_t want);
    sum_term_t res [$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= c;
    term_coeff_i <= co;
    term_exp_i   <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (c != CMD_UNUSED) items_sent++;
    case (c)
      CMD_LOAD_FIRST: begin
        if (poly_a_cnt < MAX_TERMS) begin
          poly_a_coeff[poly_a_cnt] = co;
          poly_a_exp[poly_a_cnt]   = e;
          poly_a_cnt++;
        end else begin
          terms_refused = 1'b1;
        end
      end
      CMD_LOAD_SECOND: begin
        if (poly_b_cnt < MAX_TERMS) begin
          poly_b_coeff[poly_b_cnt] = co;
          poly_b_exp[poly_b_cnt]   = e;
          poly_b_cnt++;
        end else begin
          terms_refused = 1'b1;
        end
      end
      CMD_START: begin
        merge_sum_terms(res);
        if (typed) sum_terms_due.push_back(want);
        else foreach (res[k]) sum_terms_due.push_back(res[k]);
      end
      default: ;
    endcase
  endtask

  // one pair of polynomials over a common ascending exponent walk, then start; noisy scrambles some exponents
  task automatic send_poly_pair(int nterm, bit overload, bit noisy);
    int e;
    int gap_max;
    int pick;
    int na;
    int nb;
    logic signed [COEFF_W-1:0] ca;
    logic signed [COEFF_W-1:0] cb;
    logic [EXP_W-1:0] eo;
    na = 0;
    nb = 0;
    if (nterm > 0 && $urandom_range(0, 3) == 0) begin
      e = 256 - nterm;
      gap_max = 1;
    end else begin
      e = $urandom_range(0, 20);
      gap_max = 7;
    end
    for (int k = 0; k < nterm; k++) begin
      if (k > 0) e += $urandom_range(1, gap_max);
      pick = $urandom_range(0, 2);
      ca = rand_coeff();
      cb = ($urandom_range(0, 2) == 0) ? -ca : rand_coeff();
      eo = e[EXP_W-1:0];
      if (noisy && $urandom_range(0, 9) == 0)
        send_req(CMD_UNUSED, rand_coeff(), EXP_W'($urandom), 1'b0, '0);
      if (noisy && $urandom_range(0, 7) == 0) eo = EXP_W'($urandom);
      if (pick != 1 && (na < MAX_TERMS || overload)) begin
        send_req(CMD_LOAD_FIRST, ca, eo, 1'b0, '0);
        na++;
      end
      if (pick != 0 && (nb < MAX_TERMS || overload)) begin
        send_req(CMD_LOAD_SECOND, cb, eo, 1'b0, '0);
        nb++;
      end
    end
    send_req(CMD_START, rand_coeff(), EXP_W'($urandom), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sum_terms_due.size() == 0) begin
        $error("unexpected sum term: coeff %0d exp %0d", sum_coeff_o, sum_exp_o);
        err_count++;
      end else begin
        due = sum_terms_due.pop_front();
        if (sum_coeff_o !== due.coeff) begin
          $error("sum_coeff: expected %0d, got %0d", due.coeff, sum_coeff_o);
          err_count++;
        end
        if (sum_exp_o !== due.sexp) begin
          $error("sum_exp: expected %0d, got %0d", due.sexp, sum_exp_o);
          err_count++;
        end
        if (is_last_o !== due.last) begin
          $error("is_last: expected %0b, got %0b", due.last, is_last_o);
          err_count++;
        end
        if (is_zero_o !== due.zero) begin
          $error("is_zero: expected %0b, got %0b", due.zero, is_zero_o);
          err_count++;
        end
        if (dropped_o !== due.drop) begin
          $error("dropped: expected %0b, got %0b", due.drop, dropped_o);
          err_count++;
        end
      end
    end
    if (hold_pending) begin
      hold_left = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sparse_polynomial_adder");
      $finish;
    end
  end

  initial begin
    int nterm;
    int target;
    dir_row_t r;

    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b1, mk_res(0, 0, 1, 1, 0)));
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, 32767, 0, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_SECOND, 32767, 0, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b1, mk_res(65534, 0, 1, 0, 0)));
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, -32768, 255, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_SECOND, -32768, 255, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b1, mk_res(-65536, 255, 1, 0, 0)));
    // cancelling pair
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, 5, 3, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_SECOND, -5, 3, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b1, mk_res(0, 0, 1, 1, 0)));
    dir_rows.push_back(mk_row(CMD_UNUSED, 1234, 7, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, -1, 255, 1, 1'b1, mk_res(0, 0, 1, 1, 0)));
    // zero coefficient, unsorted second, repeated exponent in first
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, 0, 1, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_SECOND, 77, 9, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_SECOND, 9, 2, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, 21, 2, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, -3, 2, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b0, '0));
    // full stores, refused terms
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, -100, 0, 17, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_FIRST, 1000, 0, 16, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_SECOND, -2000, 1, 17, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_LOAD_SECOND, 300, 200, 17, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_START, 0, 0, 1, 1'b0, '0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 12;
    recv_stall_pct = 70;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      for (int k = 0; k < r.reps; k++)
        send_req(r.cmd, r.coeff + COEFF_W'(k), r.texp + EXP_W'(3 * k), r.typed, r.want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 12 : (ph == 1) ? 70 : 0;
      recv_stall_pct = (ph == 0) ? 70 : (ph == 1) ? 12 : 0;
      target = items_sent + ITEMS_PER_PHASE;
      if (ph != 1) begin
        // long output hold while the next requests keep coming
        hold_pending = 1'b1;
        send_poly_pair(24, 1'b0, 1'b0);
      end
      while (items_sent < target) begin
        nterm = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 28) : $urandom_range(0, 8);
        send_poly_pair(nterm, nterm > 16 && $urandom_range(0, 1) == 1,
                       $urandom_range(0, 4) == 0);
      end
    end
    in_valid_i <= 1'b0;

    while (sum_terms_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS sparse_polynomial_adder");
    end else begin
      $display("FAIL sparse_polynomial_adder");
    end
    $finish;
  end

endmodule
